>>> src/iol_pkg.sv
`default_nettype none
// ----------------------------------------------------------------------------
// iol_pkg
// shared types and constants for the indexed ordered list core
// ----------------------------------------------------------------------------
package iol_pkg;

	// fixed field widths of the request and response channels
	localparam int OP_W    = 2;
	localparam int POS_W   = 5;
	localparam int DIN_W   = 32;
	localparam int DOUT_W  = 32;
	localparam int COUNT_W = 5;
	localparam int WIDE_W  = 64;

	// default build values
	localparam int CAPACITY_DEF   = 16;
	localparam int DATA_WIDTH_DEF = 32;

	// request kinds
	typedef enum logic [OP_W-1:0] {
		OP_INSERT = 2'd0,
		OP_REMOVE = 2'd1,
		OP_READ   = 2'd2
	} iol_op_t;

	// shift command broadcast to every cell of the chain
	typedef struct packed {
		logic             ins;
		logic             rem;
		logic [POS_W-1:0] pos;
	} iol_cmd_t;

endpackage
`default_nettype wire

>>> src/iol_if.sv
`default_nettype none
// ----------------------------------------------------------------------------
// iol_req_if / iol_rsp_if
// valid/ready channels for list requests and their results
// ----------------------------------------------------------------------------
interface iol_req_if;
	logic                         valid;
	logic                         ready;
	logic [iol_pkg::OP_W-1:0]     op;
	logic [iol_pkg::POS_W-1:0]    position;
	logic [iol_pkg::DIN_W-1:0]    data_in;

	modport source (output valid, output op, output position, output data_in, input ready);
	modport sink   (input valid, input op, input position, input data_in, output ready);
endinterface

interface iol_rsp_if;
	logic                         valid;
	logic                         ready;
	logic                         ok;
	logic [iol_pkg::DOUT_W-1:0]   data_out;
	logic [iol_pkg::COUNT_W-1:0]  count;

	modport source (output valid, output ok, output data_out, output count, input ready);
	modport sink   (input valid, input ok, input data_out, input count, output ready);
endinterface
`default_nettype wire

>>> src/iol_cell.sv
`default_nettype none
// ----------------------------------------------------------------------------
// iol_cell
// one list slot: loads the new word, takes its lower or upper neighbor, or holds
// ----------------------------------------------------------------------------
module iol_cell #(
	parameter int IDX = 0,
	parameter int DW  = iol_pkg::DATA_WIDTH_DEF
) (
	input  wire logic              clk,
	input  wire iol_pkg::iol_cmd_t cmd,
	input  wire logic [DW-1:0]     word,
	input  wire logic [DW-1:0]     prev,
	input  wire logic [DW-1:0]     next,
	output logic      [DW-1:0]     entry
);

	logic [DW-1:0] entry_q;
	logic          at_pos;
	logic          above_pos;

	// where this slot sits relative to the targeted index
	assign at_pos    = (IDX == int'(cmd.pos));
	assign above_pos = (IDX > int'(cmd.pos));

	// slot update: insert opens a gap, remove closes it
	always_ff @(posedge clk) begin
		if (cmd.ins && at_pos) begin
			entry_q <= word;
		end else if (cmd.ins && above_pos) begin
			entry_q <= prev;
		end else if (cmd.rem && (at_pos || above_pos)) begin
			entry_q <= next;
		end
	end

	assign entry = entry_q;

endmodule
`default_nettype wire

>>> src/indexed_ordered_list_core.sv
`default_nettype none
// ----------------------------------------------------------------------------
// indexed_ordered_list_core
// bounded ordered list of words addressed by position, built as a shifting chain
// ----------------------------------------------------------------------------
// The list is a row of CAPACITY slots, one register per entry. An insert moves
// every slot above the target up by one and loads the new word, a remove moves
// every slot from the target on down by one, and a read selects the slot at the
// target; all of this happens on the clock edge that accepts the request,
// so the core takes one request per cycle. The result sits in an output register
// and appears in the cycle after the request is accepted; a new request is taken
// while a result waits only if that result is taken in the same cycle. Requests
// that target a position outside the list, an insert into a full list and an
// unknown request kind return ok low with the list unchanged. Only the low
// DATA_WIDTH bits of data_in are stored, and count reports the low five bits of
// the number of entries held.
// ----------------------------------------------------------------------------
module indexed_ordered_list_core #(
	parameter int CAPACITY   = iol_pkg::CAPACITY_DEF,
	parameter int DATA_WIDTH = iol_pkg::DATA_WIDTH_DEF
) (
	input  wire logic  clk,
	input  wire logic  arst_n,
	iol_req_if.sink    req,
	iol_rsp_if.source  rsp
);

	localparam int HW = $clog2(CAPACITY + 1);
	localparam int IW = $clog2(CAPACITY);
	localparam int CW = (HW > iol_pkg::POS_W) ? HW : iol_pkg::POS_W;

	logic [HW-1:0]         held_q;
	logic [HW-1:0]         held_nxt;
	logic                  out_valid_q;
	logic                  ok_q;
	logic [iol_pkg::DOUT_W-1:0]  data_q;
	logic [iol_pkg::COUNT_W-1:0] count_q;

	logic                  acc;
	logic [CW-1:0]         pos_x;
	logic [CW-1:0]         held_x;
	logic                  is_ins;
	logic                  is_rem;
	logic                  is_rd;
	logic                  ins_ok;
	logic                  rem_ok;
	logic                  rd_ok;
	logic [iol_pkg::WIDE_W-1:0] word_wide;
	logic [DATA_WIDTH-1:0] word;
	logic [iol_pkg::WIDE_W-1:0] rd_wide;
	logic [CW-1:0]         held_nxt_x;
	iol_pkg::iol_cmd_t     cmd;
	logic [DATA_WIDTH-1:0] entries [CAPACITY];

	// request handshake: output register frees up or is being drained
	assign req.ready = !out_valid_q || rsp.ready;
	assign acc       = req.valid && req.ready;

	// decode and range checks
	assign pos_x  = CW'(req.position);
	assign held_x = CW'(held_q);
	assign is_ins = (req.op == iol_pkg::OP_INSERT);
	assign is_rem = (req.op == iol_pkg::OP_REMOVE);
	assign is_rd  = (req.op == iol_pkg::OP_READ);
	assign ins_ok = is_ins && (pos_x <= held_x) && (held_q < HW'(CAPACITY));
	assign rem_ok = is_rem && (pos_x < held_x);
	assign rd_ok  = is_rd && (pos_x < held_x);

	// stored word is the low data width bits of the request
	assign word_wide = {{(iol_pkg::WIDE_W - iol_pkg::DIN_W){1'b0}}, req.data_in};
	assign word      = word_wide[DATA_WIDTH-1:0];

	// shift command to the chain, only for accepted requests that succeed
	assign cmd.ins = acc && ins_ok;
	assign cmd.rem = acc && rem_ok;
	assign cmd.pos = req.position;

	// chain of slots
	for (genvar i = 0; i < CAPACITY; i++) begin : g_cell
		logic [DATA_WIDTH-1:0] prev_w;
		logic [DATA_WIDTH-1:0] next_w;

		if (i == 0) begin : g_first
			assign prev_w = word;
		end else begin : g_mid_prev
			assign prev_w = entries[i-1];
		end

		if (i == CAPACITY - 1) begin : g_last
			assign next_w = entries[i];
		end else begin : g_mid_next
			assign next_w = entries[i+1];
		end

		iol_cell #(
			.IDX (i),
			.DW  (DATA_WIDTH)
		) u_cell (
			.clk   (clk),
			.cmd   (cmd),
			.word  (word),
			.prev  (prev_w),
			.next  (next_w),
			.entry (entries[i])
		);
	end

	// read select, widened then cut to the response width
	always_comb begin
		rd_wide = '0;
		if (rd_ok) begin
			rd_wide = iol_pkg::WIDE_W'(entries[pos_x[IW-1:0]]);
		end
	end

	// length after this request
	always_comb begin
		held_nxt = held_q;
		if (ins_ok) begin
			held_nxt = held_q + 1'b1;
		end else if (rem_ok) begin
			held_nxt = held_q - 1'b1;
		end
	end
	assign held_nxt_x = CW'(held_nxt);

	// length and response valid
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			held_q      <= '0;
			out_valid_q <= 1'b0;
		end else begin
			if (acc) begin
				held_q <= held_nxt;
			end
			if (acc) begin
				out_valid_q <= 1'b1;
			end else if (rsp.ready) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	// response payload
	always_ff @(posedge clk) begin
		if (acc) begin
			ok_q    <= ins_ok || rem_ok || rd_ok;
			data_q  <= rd_wide[iol_pkg::DOUT_W-1:0];
			count_q <= held_nxt_x[iol_pkg::COUNT_W-1:0];
		end
	end

	assign rsp.valid    = out_valid_q;
	assign rsp.ok       = ok_q;
	assign rsp.data_out = data_q;
	assign rsp.count    = count_q;

	// length never passes the number of slots
	a_held_bound: assert property (@(posedge clk) disable iff (!arst_n)
		held_q <= HW'(CAPACITY))
		else $error("list length above capacity");

	// a successful insert grows the list by exactly one
	a_ins_grow: assert property (@(posedge clk) disable iff (!arst_n)
		(acc && ins_ok) |=> (held_q == HW'($past(held_q) + 1'b1)))
		else $error("insert did not grow the list by one");

	// a successful remove shrinks the list by exactly one
	a_rem_shrink: assert property (@(posedge clk) disable iff (!arst_n)
		(acc && rem_ok) |=> (held_q == HW'($past(held_q) - 1'b1)))
		else $error("remove did not shrink the list by one");

	// every accepted request shows a response in the next cycle
	a_rsp_follows: assert property (@(posedge clk) disable iff (!arst_n)
		acc |=> rsp.valid)
		else $error("accepted request without response");

endmodule
`default_nettype wire

>>> test/indexed_ordered_list_core_tb.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// indexed_ordered_list_core_tb
// self-checking bench for the positional list core
// ----------------------------------------------------------------------------
// A queue of requests is built up front: a directed opening that covers the
// empty list, inserts at the front, middle and end, removes at both ends,
// indexes past the end and the unknown request kind, then random traffic in
// phases that favor filling, draining or a mix, so the list runs full and
// empty many times. Every accepted request is run through a local copy of the
// list, and each response is compared field by field with the oldest
// prediction. Both channels idle at random, with one calm window, and the
// response side holds off once for a long stretch to back the core up.
// ----------------------------------------------------------------------------
module indexed_ordered_list_core_tb;

	localparam int LIST_DEPTH     = iol_pkg::CAPACITY_DEF;
	localparam int IDLE_PCT       = 37;
	localparam int RANDOM_ITEMS   = 1750;
	localparam int PHASE_LEN      = 60;
	localparam int CALM_FIRST     = 2500;
	localparam int CALM_LAST      = 3300;
	localparam int HOLD_AFTER     = 400;
	localparam int HOLD_CYCLES    = 300;
	localparam int STALL_LIMIT    = 2000;
	localparam int DRAIN_CYCLES   = 8;
	localparam int REPORT_MAX     = 10;

	// request kind outside the enum
	localparam logic [iol_pkg::OP_W-1:0] OP_UNKNOWN = 2'd3;

	typedef struct {
		logic [iol_pkg::OP_W-1:0]  op;
		logic [iol_pkg::POS_W-1:0] pos;
		logic [iol_pkg::DIN_W-1:0] word;
	} list_request_t;

	typedef struct {
		logic                        ok;
		logic [iol_pkg::DOUT_W-1:0]  word;
		logic [iol_pkg::COUNT_W-1:0] count;
	} list_result_t;

	logic clk = 1'b0;
	logic arst_n = 1'b0;

	iol_req_if req_ch ();
	iol_rsp_if rsp_ch ();

	indexed_ordered_list_core uut (
		.clk    (clk),
		.arst_n (arst_n),
		.req    (req_ch),
		.rsp    (rsp_ch)
	);

	always #2 clk = ~clk;

	list_request_t pending_requests[$];
	list_result_t  expected_results[$];

	// shadow copy of the list
	logic [iol_pkg::DIN_W-1:0] shadow_words [LIST_DEPTH];
	int                        shadow_len = 0;

	// length seen by the request builder, used to aim positions
	int plan_len = 0;

	int  mismatch_count = 0;
	int  results_seen = 0;
	int  stall_cycles = 0;
	int  cycle_no = 0;
	int  hold_left = 0;
	bit  hold_done = 1'b0;
	wire calm_window = (cycle_no >= CALM_FIRST) && (cycle_no < CALM_LAST);

	// apply one request to the shadow list and return its response
	function automatic list_result_t apply_list_request(logic [iol_pkg::OP_W-1:0] op,
			logic [iol_pkg::POS_W-1:0] pos, logic [iol_pkg::DIN_W-1:0] word);
		list_result_t res;
		int idx;
		res.ok = 1'b0;
		res.word = '0;
		case (iol_pkg::iol_op_t'(op))
			iol_pkg::OP_INSERT: begin
				if (pos <= shadow_len && shadow_len < LIST_DEPTH) begin
					for (idx = shadow_len; idx > pos; idx--)
						shadow_words[idx] = shadow_words[idx-1];
					shadow_words[pos] = word;
					shadow_len++;
					res.ok = 1'b1;
				end
			end
			iol_pkg::OP_REMOVE: begin
				if (pos < shadow_len) begin
					for (idx = pos; idx + 1 < shadow_len; idx++)
						shadow_words[idx] = shadow_words[idx+1];
					shadow_len--;
					res.ok = 1'b1;
				end
			end
			iol_pkg::OP_READ: begin
				if (pos < shadow_len) begin
					res.word = shadow_words[pos];
					res.ok = 1'b1;
				end
			end
			default: ;
		endcase
		res.count = shadow_len[iol_pkg::COUNT_W-1:0];
		return res;
	endfunction

	// queue a request and track the length it leaves behind
	task automatic queue_request(logic [iol_pkg::OP_W-1:0] op,
			logic [iol_pkg::POS_W-1:0] pos, logic [iol_pkg::DIN_W-1:0] word);
		list_request_t r;
		r.op = op;
		r.pos = pos;
		r.word = word;
		pending_requests.push_back(r);
		if (op == iol_pkg::OP_INSERT && pos <= plan_len && plan_len < LIST_DEPTH)
			plan_len++;
		else if (op == iol_pkg::OP_REMOVE && pos < plan_len)
			plan_len--;
	endtask

	// request driver
	always @(posedge clk) begin
		list_request_t next_req;
		if (!arst_n) begin
			req_ch.valid <= 1'b0;
		end else begin
			if (req_ch.valid && req_ch.ready)
				expected_results.push_back(apply_list_request(req_ch.op,
					req_ch.position, req_ch.data_in));
			if (!req_ch.valid || req_ch.ready) begin
				if (pending_requests.size() != 0 &&
						(calm_window || $urandom_range(99) >= IDLE_PCT)) begin
					next_req = pending_requests.pop_front();
					req_ch.op <= next_req.op;
					req_ch.position <= next_req.pos;
					req_ch.data_in <= next_req.word;
					req_ch.valid <= 1'b1;
				end else begin
					req_ch.valid <= 1'b0;
				end
			end
		end
	end

	// response monitor and ready control
	always @(posedge clk) begin
		list_result_t exp_res;
		if (!arst_n) begin
			rsp_ch.ready <= 1'b0;
		end else begin
			if (rsp_ch.valid && rsp_ch.ready) begin
				results_seen++;
				if (expected_results.size() == 0) begin
					mismatch_count++;
					if (mismatch_count <= REPORT_MAX)
						$display("unexpected response %0d:", results_seen,
							" ok=%0d data_out=%h count=%0d",
							rsp_ch.ok, rsp_ch.data_out, rsp_ch.count);
				end else begin
					exp_res = expected_results.pop_front();
					if (rsp_ch.ok !== exp_res.ok || rsp_ch.data_out !== exp_res.word ||
							rsp_ch.count !== exp_res.count) begin
						mismatch_count++;
						if (mismatch_count <= REPORT_MAX)
							$display("response %0d mismatch:", results_seen,
								" expected ok=%0d data_out=%h count=%0d,",
								exp_res.ok, exp_res.word, exp_res.count,
								" got ok=%0d data_out=%h count=%0d",
								rsp_ch.ok, rsp_ch.data_out, rsp_ch.count);
					end
				end
			end
			// one long hold-off to back the core up
			if (hold_left != 0) begin
				hold_left <= hold_left - 1;
				rsp_ch.ready <= 1'b0;
			end else if (!hold_done && results_seen >= HOLD_AFTER) begin
				hold_done <= 1'b1;
				hold_left <= HOLD_CYCLES;
				rsp_ch.ready <= 1'b0;
			end else begin
				rsp_ch.ready <= calm_window || ($urandom_range(99) >= IDLE_PCT);
			end
		end
	end

	// cycle count and stall watchdog
	always @(posedge clk) begin
		cycle_no <= cycle_no + 1;
		if ((req_ch.valid && req_ch.ready) || (rsp_ch.valid && rsp_ch.ready)) begin
			stall_cycles <= 0;
		end else if (stall_cycles + 1 >= STALL_LIMIT) begin
			$display("TB_ERROR");
			$finish;
		end else begin
			stall_cycles <= stall_cycles + 1;
		end
	end

	// stimulus and end of run
	initial begin
		int n;
		int phase;
		int roll;
		logic [iol_pkg::OP_W-1:0]  op;
		logic [iol_pkg::POS_W-1:0] pos;
		logic [iol_pkg::DIN_W-1:0] word;

		req_ch.valid = 1'b0;
		req_ch.op = iol_pkg::OP_INSERT;
		req_ch.position = '0;
		req_ch.data_in = '0;
		rsp_ch.ready = 1'b0;

		// directed: empty list, both ends, middle, past the end, unknown kind
		queue_request(OP_UNKNOWN, 5'd0, '1);
		queue_request(iol_pkg::OP_READ, 5'd0, '0);
		queue_request(iol_pkg::OP_REMOVE, 5'd0, '0);
		queue_request(iol_pkg::OP_INSERT, 5'd1, 32'h1234_5678);
		queue_request(iol_pkg::OP_INSERT, 5'd0, '1);
		queue_request(iol_pkg::OP_INSERT, 5'd1, '0);
		queue_request(iol_pkg::OP_INSERT, 5'd0, 32'h5a5a_a5a5);
		queue_request(iol_pkg::OP_INSERT, 5'd2, 32'h8000_0001);
		queue_request(iol_pkg::OP_READ, 5'd0, '1);
		queue_request(iol_pkg::OP_READ, 5'd1, '0);
		queue_request(iol_pkg::OP_READ, 5'd2, '0);
		queue_request(iol_pkg::OP_READ, 5'd3, '0);
		queue_request(iol_pkg::OP_READ, 5'd4, '0);
		queue_request(iol_pkg::OP_READ, 5'd31, '0);
		queue_request(iol_pkg::OP_INSERT, 5'd31, 32'hdead_beef);
		queue_request(iol_pkg::OP_INSERT, 5'd5, 32'hcafe_f00d);
		queue_request(iol_pkg::OP_REMOVE, 5'd4, '0);
		queue_request(iol_pkg::OP_REMOVE, 5'd3, '0);
		queue_request(iol_pkg::OP_REMOVE, 5'd0, '0);
		queue_request(OP_UNKNOWN, 5'd31, '1);
		queue_request(iol_pkg::OP_READ, 5'd1, '0);
		queue_request(iol_pkg::OP_REMOVE, 5'd16, '0);

		// random phases: fill, drain or mixed
		phase = 0;
		for (n = 0; n < RANDOM_ITEMS; n++) begin
			if (n % PHASE_LEN == 0)
				phase = $urandom_range(2);
			roll = $urandom_range(99);
			case (phase)
				0: op = (roll < 70) ? iol_pkg::OP_INSERT : (roll < 80) ? iol_pkg::OP_REMOVE :
					(roll < 97) ? iol_pkg::OP_READ : OP_UNKNOWN;
				1: op = (roll < 60) ? iol_pkg::OP_REMOVE : (roll < 75) ? iol_pkg::OP_INSERT :
					(roll < 97) ? iol_pkg::OP_READ : OP_UNKNOWN;
				default: op = (roll < 35) ? iol_pkg::OP_INSERT :
					(roll < 65) ? iol_pkg::OP_REMOVE :
					(roll < 97) ? iol_pkg::OP_READ : OP_UNKNOWN;
			endcase
			// mostly in-range positions, some anywhere in the field
			if ($urandom_range(9) < 8) begin
				if (op == iol_pkg::OP_INSERT)
					pos = iol_pkg::POS_W'($urandom_range(plan_len));
				else
					pos = (plan_len == 0) ? 5'd0 :
						iol_pkg::POS_W'($urandom_range(plan_len - 1));
			end else begin
				pos = iol_pkg::POS_W'($urandom_range(31));
			end
			roll = $urandom_range(99);
			word = (roll < 5) ? '0 : (roll < 10) ? '1 : $urandom;
			queue_request(op, pos, word);
		end

		repeat (7) @(posedge clk);
		arst_n <= 1'b1;

		while (pending_requests.size() != 0 || req_ch.valid)
			@(posedge clk);
		while (expected_results.size() != 0)
			@(posedge clk);
		repeat (DRAIN_CYCLES) @(posedge clk);
		if (mismatch_count == 0)
			$display("TB_OK");
		else
			$display("TB_ERROR");
		$finish;
	end

endmodule
